### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro takes a label, the clock, the active-low reset, a condition
// and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/tbp_pkg.sv
`default_nettype none

package tbp_pkg;

  // Widths of the channel fields, the configuration register and the counters.
  localparam int ADDR_W = 32;
  localparam int CNT_W  = 32;
  localparam int HLEN_W = 4;
  localparam int CTR_W  = 2;

  // Reset values.
  localparam logic [HLEN_W-1:0] HLEN_RESET      = 4'd11;
  localparam logic [CTR_W-1:0]  CTR_STRONG_TAKEN = 2'd3;
  localparam logic [CTR_W-1:0]  CTR_STRONG_NOT   = 2'd0;

  // Output buffer depth, in results.
  localparam int OBUF_DEPTH = 2;

  typedef struct packed {
    logic             predicted_taken;
    logic             prediction_correct;
    logic             bimodal_correct;
    logic             gshare_correct;
    logic             used_bimodal;
    logic [CNT_W-1:0] correct_total;
    logic [CNT_W-1:0] branch_total;
  } result_t;

  // Two-bit saturating counter step.
  function automatic logic [CTR_W-1:0] train2(input logic [CTR_W-1:0] c, input logic up);
    logic [CTR_W-1:0] r;
    r = c;
    if (up) begin
      if (c != CTR_STRONG_TAKEN) r = c + 2'd1;
    end else begin
      if (c != CTR_STRONG_NOT) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/tbp_intf.sv
`default_nettype none

// Resolved-branch channel.
interface tbp_in_if;
  logic                      valid;
  logic                      ready;
  logic [tbp_pkg::ADDR_W-1:0] branch_address;
  logic                      actual_taken;

  modport source (output valid, output branch_address, output actual_taken, input ready);
  modport sink   (input valid, input branch_address, input actual_taken, output ready);
endinterface

// Prediction result channel.
interface tbp_out_if;
  logic                      valid;
  logic                      ready;
  logic                      predicted_taken;
  logic                      prediction_correct;
  logic                      bimodal_correct;
  logic                      gshare_correct;
  logic                      used_bimodal;
  logic [tbp_pkg::CNT_W-1:0] correct_total;
  logic [tbp_pkg::CNT_W-1:0] branch_total;

  modport source (output valid, output predicted_taken, output prediction_correct,
                  output bimodal_correct, output gshare_correct, output used_bimodal,
                  output correct_total, output branch_total, input ready);
  modport sink   (input valid, input predicted_taken, input prediction_correct,
                  input bimodal_correct, input gshare_correct, input used_bimodal,
                  input correct_total, input branch_total, output ready);
endinterface

`default_nettype wire

### rtl/tournament_branch_predictor_top.sv
// A branch is registered in stage one and its result in the output buffer.
// Throughput: one branch per cycle while in_chan.ready is high; a same-entry
// update from the previous branch is forwarded around the counter RAMs, and
// in_chan.ready drops only during table initialisation or when no slot is free.
// Reset: synchronous, active low; then the three counter tables are initialised
// one entry per cycle, all 2**INDEX_BITS (2048 by default); cfg writes are taken.
`default_nettype none

module tournament_branch_predictor_top #(
  parameter int INDEX_BITS = 11
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  tbp_in_if.sink                          in_chan,
  tbp_out_if.source                       out_chan,
  input  wire logic                       cfg_we,
  input  wire logic [tbp_pkg::HLEN_W-1:0] cfg_wdata
);

  localparam int DEPTH = 1 << INDEX_BITS;
  localparam int CTR_W = tbp_pkg::CTR_W;
  localparam int CNT_W = tbp_pkg::CNT_W;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [CTR_W-1:0]      ctr_t;

  // Configuration and global state.
  logic [tbp_pkg::HLEN_W-1:0] hlen_r;
  idx_t                       hist_r;
  logic                       clr_busy_r;
  idx_t                       clr_idx_r;

  // Stage one (RAM read data is valid here).
  logic s1_valid_r;
  idx_t s1_bi_r;
  idx_t s1_gi_r;
  logic s1_taken_r;

  // Last write to the tables, for same-entry forwarding.
  logic fwd_valid_r;
  idx_t fwd_bi_r;
  idx_t fwd_gi_r;
  ctr_t fwd_b_r;
  ctr_t fwd_g_r;
  ctr_t fwd_c_r;

  // Running totals.
  logic [CNT_W-1:0] correct_r;
  logic [CNT_W-1:0] branch_r;

  // Output buffer.
  tbp_pkg::result_t obuf_r [tbp_pkg::OBUF_DEPTH];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;

  logic             in_fire;
  logic             out_fire;
  logic [2:0]       occ;
  idx_t             hmask;
  idx_t             in_bi;
  idx_t             in_gi;

  ctr_t             b_rdata;
  ctr_t             g_rdata;
  ctr_t             c_rdata;
  ctr_t             b_ctr;
  ctr_t             g_ctr;
  ctr_t             c_ctr;
  logic             bpred;
  logic             gpred;
  logic             bok;
  logic             gok;
  logic             disagree;
  logic             use_b;
  logic             pred;
  logic             ok;
  ctr_t             b_new;
  ctr_t             g_new;
  ctr_t             c_new;
  logic [CNT_W-1:0] correct_nxt;
  logic [CNT_W-1:0] branch_nxt;
  tbp_pkg::result_t res;

  logic             ram_we;
  idx_t             b_waddr;
  idx_t             g_waddr;
  ctr_t             b_wdata;
  ctr_t             g_wdata;
  ctr_t             c_wdata;

  // Handshake. Every item in flight has a buffer slot reserved for it.
  assign out_fire = out_chan.valid && out_chan.ready;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign occ      = {1'b0, cnt_r} + {2'b00, s1_valid_r} - {2'b00, out_fire};
  assign in_chan.ready = !clr_busy_r && (occ < 3'(tbp_pkg::OBUF_DEPTH));

  // History mask: the low history_length bits, limited to the index width.
  always_comb begin
    for (int i = 0; i < INDEX_BITS; i++) begin
      hmask[i] = (i < int'(hlen_r));
    end
  end

  assign in_bi = in_chan.branch_address[INDEX_BITS-1:0];
  assign in_gi = in_bi ^ (hist_r & hmask);

  // Counter tables.
  tbp_ram #(.WIDTH(CTR_W), .DEPTH(DEPTH)) u_bimodal (
    .clk(clk), .we(ram_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(in_bi), .rdata(b_rdata)
  );

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(DEPTH)) u_gshare (
    .clk(clk), .we(ram_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(in_gi), .rdata(g_rdata)
  );

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(DEPTH)) u_chooser (
    .clk(clk), .we(ram_we), .waddr(b_waddr), .wdata(c_wdata),
    .raddr(in_bi), .rdata(c_rdata)
  );

  // Counter values with the previous branch's update forwarded.
  always_comb begin
    b_ctr = (fwd_valid_r && (fwd_bi_r == s1_bi_r)) ? fwd_b_r : b_rdata;
    c_ctr = (fwd_valid_r && (fwd_bi_r == s1_bi_r)) ? fwd_c_r : c_rdata;
    g_ctr = (fwd_valid_r && (fwd_gi_r == s1_gi_r)) ? fwd_g_r : g_rdata;
  end

  // Prediction, checks and training.
  always_comb begin
    bpred    = b_ctr[CTR_W-1];
    gpred    = g_ctr[CTR_W-1];
    bok      = (bpred == s1_taken_r);
    gok      = (gpred == s1_taken_r);
    disagree = (bpred != gpred);
    use_b    = disagree && c_ctr[CTR_W-1];
    pred     = disagree ? (c_ctr[CTR_W-1] ? bpred : gpred) : bpred;
    ok       = (pred == s1_taken_r);
    b_new    = tbp_pkg::train2(b_ctr, s1_taken_r);
    g_new    = tbp_pkg::train2(g_ctr, s1_taken_r);
    c_new    = disagree ? tbp_pkg::train2(c_ctr, bok) : c_ctr;

    correct_nxt = (ok && (correct_r != '1)) ? correct_r + CNT_W'(1) : correct_r;
    branch_nxt  = (branch_r != '1) ? branch_r + CNT_W'(1) : branch_r;

    res.predicted_taken    = pred;
    res.prediction_correct = ok;
    res.bimodal_correct    = bok;
    res.gshare_correct     = gok;
    res.used_bimodal       = use_b;
    res.correct_total      = correct_nxt;
    res.branch_total       = branch_nxt;
  end

  // Table write port: the clearing pass, then training updates.
  always_comb begin
    ram_we = clr_busy_r || s1_valid_r;
    if (clr_busy_r) begin
      b_waddr = clr_idx_r;
      g_waddr = clr_idx_r;
      b_wdata = tbp_pkg::CTR_STRONG_TAKEN;
      g_wdata = tbp_pkg::CTR_STRONG_TAKEN;
      c_wdata = tbp_pkg::CTR_STRONG_NOT;
    end else begin
      b_waddr = s1_bi_r;
      g_waddr = s1_gi_r;
      b_wdata = b_new;
      g_wdata = g_new;
      c_wdata = c_new;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hlen_r      <= tbp_pkg::HLEN_RESET;
      hist_r      <= '0;
      clr_busy_r  <= 1'b1;
      clr_idx_r   <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      correct_r   <= '0;
      branch_r    <= '0;
      wr_ptr_r    <= 1'b0;
      rd_ptr_r    <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        hlen_r <= cfg_wdata;
      end
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + idx_t'(1);
        if (clr_idx_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (in_fire) begin
        hist_r <= {hist_r[INDEX_BITS-2:0], in_chan.actual_taken};
      end
      s1_valid_r <= in_fire;
      if (s1_valid_r) begin
        fwd_valid_r <= 1'b1;
        correct_r   <= correct_nxt;
        branch_r    <= branch_nxt;
        wr_ptr_r    <= !wr_ptr_r;
      end
      if (out_fire) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, s1_valid_r} - {1'b0, out_fire};
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_bi_r    <= in_bi;
      s1_gi_r    <= in_gi;
      s1_taken_r <= in_chan.actual_taken;
    end
    if (s1_valid_r) begin
      fwd_bi_r         <= s1_bi_r;
      fwd_gi_r         <= s1_gi_r;
      fwd_b_r          <= b_new;
      fwd_g_r          <= g_new;
      fwd_c_r          <= c_new;
      obuf_r[wr_ptr_r] <= res;
    end
  end

  // Result channel.
  assign out_chan.valid              = (cnt_r != 2'd0);
  assign out_chan.predicted_taken    = obuf_r[rd_ptr_r].predicted_taken;
  assign out_chan.prediction_correct = obuf_r[rd_ptr_r].prediction_correct;
  assign out_chan.bimodal_correct    = obuf_r[rd_ptr_r].bimodal_correct;
  assign out_chan.gshare_correct     = obuf_r[rd_ptr_r].gshare_correct;
  assign out_chan.used_bimodal       = obuf_r[rd_ptr_r].used_bimodal;
  assign out_chan.correct_total      = obuf_r[rd_ptr_r].correct_total;
  assign out_chan.branch_total       = obuf_r[rd_ptr_r].branch_total;

endmodule

`default_nettype wire

### rtl/tbp_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read.
// A read at the address being written returns the old contents.
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/tbp_checker.sv
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the result channel.
module tbp_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      predicted_taken,
  input wire logic                      prediction_correct,
  input wire logic                      bimodal_correct,
  input wire logic                      gshare_correct,
  input wire logic                      used_bimodal,
  input wire logic [tbp_pkg::CNT_W-1:0] correct_total,
  input wire logic [tbp_pkg::CNT_W-1:0] branch_total
);

  // Bimodal is only chosen when the two components disagree.
  `ASSERT_IMPL(a_used_bimodal_disagree, clk, rst_n, out_valid && used_bimodal, bimodal_correct != gshare_correct)

  // When bimodal is chosen the final outcome is the bimodal outcome.
  `ASSERT_IMPL(a_used_bimodal_outcome, clk, rst_n, out_valid && used_bimodal, prediction_correct == bimodal_correct)

  // On agreement the final outcome equals both component outcomes.
  `ASSERT_IMPL(a_agree_outcome, clk, rst_n, out_valid && (bimodal_correct == gshare_correct), prediction_correct == bimodal_correct)

  // Correct predictions never outnumber branches.
  `ASSERT_IMPL(a_totals_order, clk, rst_n, out_valid, correct_total <= branch_total)

  // A stalled result stays valid, and its prediction and totals hold.
  `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(predicted_taken) && $stable(branch_total) && $stable(correct_total))

endmodule

bind tournament_branch_predictor_top tbp_checker u_tbp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .predicted_taken(out_chan.predicted_taken),
  .prediction_correct(out_chan.prediction_correct),
  .bimodal_correct(out_chan.bimodal_correct),
  .gshare_correct(out_chan.gshare_correct),
  .used_bimodal(out_chan.used_bimodal),
  .correct_total(out_chan.correct_total),
  .branch_total(out_chan.branch_total)
);

`default_nettype wire
